FILE: design/assert_macros.svh
// assertion helpers included by the tessellator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_NOW(name, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/cfgt_pkg.sv
// ----------------------------------------------------------------------------
// cfgt_pkg
// shared types, register indexes, face codes and direction tables
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfgt_pkg;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_EXTENT_X = 3'd3,
        REG_EXTENT_Y = 3'd4,
        REG_EXTENT_Z = 3'd5,
        REG_U_RES    = 3'd6,
        REG_V_RES    = 3'd7
    } reg_idx_t;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    localparam int IDXW = 15;
    localparam int DIV_BPS = 8;

    typedef struct packed {
        logic            valid;
        logic            op;
        logic            tri2;
        logic [2:0]      face;
        logic [IDXW-1:0] a;
        logic [IDXW-1:0] w;
    } ctl_t;

    function automatic logic [2:0] dir_tangent(input logic [2:0] f);
        logic [2:0] d;
        case (f)
            FACE_PX: d = FACE_NZ;
            FACE_NX: d = FACE_PZ;
            FACE_NZ: d = FACE_NX;
            default: d = FACE_PX;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] dir_bitangent(input logic [2:0] f);
        logic [2:0] d;
        case (f)
            FACE_PY: d = FACE_NZ;
            FACE_NY: d = FACE_PZ;
            default: d = FACE_PY;
        endcase
        return d;
    endfunction

endpackage

FILE: design/cfgt_divider.sv
// ----------------------------------------------------------------------------
// cfgt_divider
// pipelined restoring divider, a fixed number of quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfgt_divider #(
    parameter int DW = 38,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic [DW-1:0] num,
    input  logic [VW-1:0] den,
    output logic [DW-1:0] quo
);

    localparam int BPS    = cfgt_pkg::DIV_BPS;
    localparam int STAGES = (DW + BPS - 1) / BPS;
    localparam int PW     = STAGES * BPS;

    logic [PW-1:0] n_reg [STAGES];
    logic [VW-1:0] r_reg [STAGES];
    logic [VW-1:0] d_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [PW-1:0] n_in;
        logic [VW-1:0] r_in;
        logic [VW-1:0] d_in;
        logic [PW-1:0] n_next;
        logic [VW-1:0] r_next;

        if (s == 0) begin : g_first
            assign n_in = PW'(num);
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_rest
            assign n_in = n_reg[s-1];
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
        end

        always_comb
        begin
            logic [VW:0] t;
            n_next = n_in;
            r_next = r_in;
            for (int i = 0; i < BPS; i++)
            begin
                t = {r_next, n_next[PW-1]};
                n_next = n_next << 1;
                if (t >= {1'b0, d_in})
                begin
                    t = t - {1'b0, d_in};
                    n_next[0] = 1'b1;
                end
                r_next = t[VW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[s] <= n_next;
            r_reg[s] <= r_next;
            d_reg[s] <= d_in;
        end
    end

    assign quo = n_reg[STAGES-1][DW-1:0];

endmodule

FILE: design/cube_face_grid_tessellator.sv
// ----------------------------------------------------------------------------
// cube_face_grid_tessellator
// vertex and quad-triangle generator for a cube split into six grid faces
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A vertex request
// gives one result, a quad request two (the second with last high); after a
// quad, busy is high for one cycle while the second triangle enters. Vertex
// requests may be given every cycle while busy is low. Results pass through
// the clamping stage, the product stage, the pipelined grid-step divider at
// eight quotient bits per stage, and the output register. Each result is
// held for one cycle under strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cube_face_grid_tessellator #(
    parameter int MAX_RES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [2:0]         face,
    input  logic [6:0]         row,
    input  logic [6:0]         col,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               strobe,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [2:0]         normal_dir,
    output logic [2:0]         tangent_dir,
    output logic [2:0]         bitangent_dir,
    output logic [14:0]        index_a,
    output logic [14:0]        index_b,
    output logic [14:0]        index_c,
    output logic               last
);

    localparam int IW     = cfgt_pkg::IDXW;
    localparam int RW     = $clog2(MAX_RES + 1);
    localparam int CW     = (RW > 7) ? RW : 7;
    localparam int DW     = RW + 31;
    localparam int STAGES = (DW + cfgt_pkg::DIV_BPS - 1) / cfgt_pkg::DIV_BPS;

    // configuration
    logic [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [30:0] ext_x_reg, ext_y_reg, ext_z_reg;
    logic [6:0]  u_res_reg, v_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= 32'hFFFF_0000;
            org_y_reg <= 32'hFFFF_0000;
            org_z_reg <= 32'hFFFF_0000;
            ext_x_reg <= 31'd131072;
            ext_y_reg <= 31'd131072;
            ext_z_reg <= 31'd131072;
            u_res_reg <= 7'd8;
            v_res_reg <= 7'd8;
        end
        else if (cfg_we)
        begin
            case (cfgt_pkg::reg_idx_t'(cfg_index))
                cfgt_pkg::REG_ORIGIN_X: org_x_reg <= cfg_data;
                cfgt_pkg::REG_ORIGIN_Y: org_y_reg <= cfg_data;
                cfgt_pkg::REG_ORIGIN_Z: org_z_reg <= cfg_data;
                cfgt_pkg::REG_EXTENT_X: ext_x_reg <= cfg_data[30:0];
                cfgt_pkg::REG_EXTENT_Y: ext_y_reg <= cfg_data[30:0];
                cfgt_pkg::REG_EXTENT_Z: ext_z_reg <= cfg_data[30:0];
                cfgt_pkg::REG_U_RES:    u_res_reg <= cfg_data[6:0];
                cfgt_pkg::REG_V_RES:    v_res_reg <= cfg_data[6:0];
                default:                u_res_reg <= u_res_reg;
            endcase
        end
    end

    logic [CW-1:0] u_ext, v_ext;
    logic [RW-1:0] ur, vr;

    assign u_ext = CW'(u_res_reg);
    assign v_ext = CW'(v_res_reg);
    assign ur = (u_ext == '0) ? RW'(1) : ((u_ext > CW'(MAX_RES)) ? RW'(MAX_RES) : RW'(u_ext));
    assign vr = (v_ext == '0) ? RW'(1) : ((v_ext > CW'(MAX_RES)) ? RW'(MAX_RES) : RW'(v_ext));

    // request intake; a quad re-enters once for its second triangle
    logic       take;
    logic       pend_reg, pend_next;
    logic [2:0] hold_face_reg;
    logic [6:0] hold_row_reg, hold_col_reg;

    assign take      = start && !pend_reg;
    assign busy      = pend_reg;
    assign pend_next = take && op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_face_reg <= face;
            hold_row_reg  <= row;
            hold_col_reg  <= col;
        end
    end

    // stage 1: clamping
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_op_reg, s1_op_next;
    logic          s1_tri_reg;
    logic [2:0]    s1_face_reg, s1_face_next;
    logic [RW-1:0] s1_row_reg, s1_row_next;
    logic [RW-1:0] s1_col_reg, s1_col_next;
    logic [RW-1:0] s1_ur_reg, s1_vr_reg;

    always_comb
    begin
        logic [2:0]    f;
        logic [CW-1:0] r;
        logic [CW-1:0] c;
        logic [CW-1:0] rl;
        logic [CW-1:0] cl;
        s1_valid_next = take || pend_reg;
        s1_op_next    = pend_reg ? 1'b1 : op;
        f  = pend_reg ? hold_face_reg : face;
        r  = CW'(pend_reg ? hold_row_reg : row);
        c  = CW'(pend_reg ? hold_col_reg : col);
        rl = s1_op_next ? CW'(vr - RW'(1)) : CW'(vr);
        cl = s1_op_next ? CW'(ur - RW'(1)) : CW'(ur);
        s1_face_next = (f > cfgt_pkg::FACE_NZ) ? cfgt_pkg::FACE_NZ : f;
        s1_row_next  = (r > rl) ? RW'(rl) : RW'(r);
        s1_col_next  = (c > cl) ? RW'(cl) : RW'(c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s1_op_next;
        s1_tri_reg  <= pend_reg;
        s1_face_reg <= s1_face_next;
        s1_row_reg  <= s1_row_next;
        s1_col_reg  <= s1_col_next;
        s1_ur_reg   <= ur;
        s1_vr_reg   <= vr;
    end

    // stage 2: products for the grid steps and the index terms
    logic          s2_valid_reg;
    logic          s2_op_reg, s2_tri_reg;
    logic [2:0]    s2_face_reg;
    logic [RW-1:0] s2_col_reg, s2_ur_reg, s2_vr_reg;
    logic [DW-1:0] s2_na_reg, s2_nb_reg, s2_nu_reg, s2_nv_reg;
    logic [IW-1:0] s2_vw_reg, s2_rw_reg, s2_w_reg;
    logic [30:0]   ext_a, ext_b;
    logic [RW:0]   w1, v1;

    assign ext_a = (s1_face_reg <= cfgt_pkg::FACE_NX) ? ext_z_reg : ext_x_reg;
    assign ext_b = ((s1_face_reg == cfgt_pkg::FACE_PY) || (s1_face_reg == cfgt_pkg::FACE_NY))
                   ? ext_z_reg : ext_y_reg;
    assign w1 = {1'b0, s1_ur_reg} + (RW+1)'(1);
    assign v1 = {1'b0, s1_vr_reg} + (RW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_tri_reg  <= s1_tri_reg;
        s2_face_reg <= s1_face_reg;
        s2_col_reg  <= s1_col_reg;
        s2_ur_reg   <= s1_ur_reg;
        s2_vr_reg   <= s1_vr_reg;
        s2_na_reg   <= DW'(s1_col_reg) * DW'(ext_a);
        s2_nb_reg   <= DW'(s1_row_reg) * DW'(ext_b);
        s2_nu_reg   <= DW'(s1_col_reg) << 16;
        s2_nv_reg   <= DW'(s1_row_reg) << 16;
        s2_vw_reg   <= IW'(IW'(v1) * IW'(w1));
        s2_rw_reg   <= IW'(IW'(s1_row_reg) * IW'(w1));
        s2_w_reg    <= IW'(w1);
    end

    // dividers and the matching control line
    logic [DW-1:0] q_a, q_b, q_u, q_v;

    cfgt_divider #(.DW(DW), .VW(RW)) u_div_a (.clk(clk), .num(s2_na_reg), .den(s2_ur_reg), .quo(q_a));
    cfgt_divider #(.DW(DW), .VW(RW)) u_div_b (.clk(clk), .num(s2_nb_reg), .den(s2_vr_reg), .quo(q_b));
    cfgt_divider #(.DW(DW), .VW(RW)) u_div_u (.clk(clk), .num(s2_nu_reg), .den(s2_ur_reg), .quo(q_u));
    cfgt_divider #(.DW(DW), .VW(RW)) u_div_v (.clk(clk), .num(s2_nv_reg), .den(s2_vr_reg), .quo(q_v));

    cfgt_pkg::ctl_t line_reg [STAGES];
    cfgt_pkg::ctl_t line_next;

    always_comb
    begin
        line_next.valid = s2_valid_reg;
        line_next.op    = s2_op_reg;
        line_next.tri2  = s2_tri_reg;
        line_next.face  = s2_face_reg;
        line_next.a     = IW'(IW'(s2_face_reg) * s2_vw_reg) + s2_rw_reg + IW'(s2_col_reg);
        line_next.w     = s2_w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
                line_reg[s] <= '0;
        end
        else
        begin
            line_reg[0] <= line_next;
            for (int s = 1; s < STAGES; s++)
                line_reg[s] <= line_reg[s-1];
        end
    end

    // output stage: face mapping, saturation, triangle winding
    cfgt_pkg::ctl_t ct;
    logic [30:0]    off_x, off_y, off_z;
    logic [31:0]    px_next, py_next, pz_next;
    logic [16:0]    tu_next, tv_next;
    logic [IW-1:0]  ib, ic, id;
    logic [IW-1:0]  ia_next, ib_next, ic_next;

    assign ct = line_reg[STAGES-1];

    function automatic logic [31:0] sat_add(input logic [31:0] o, input logic [30:0] d);
        logic [32:0] s;
        s = {o[31], o} + {2'b00, d};
        return (s[32:31] == 2'b01) ? 32'h7FFF_FFFF : s[31:0];
    endfunction

    always_comb
    begin
        case (ct.face)
            cfgt_pkg::FACE_PX:
            begin
                off_x = ext_x_reg;  off_y = q_b[30:0]; off_z = q_a[30:0];
            end
            cfgt_pkg::FACE_NX:
            begin
                off_x = '0;         off_y = q_b[30:0]; off_z = q_a[30:0];
            end
            cfgt_pkg::FACE_PY:
            begin
                off_x = q_a[30:0];  off_y = ext_y_reg; off_z = q_b[30:0];
            end
            cfgt_pkg::FACE_NY:
            begin
                off_x = q_a[30:0];  off_y = '0;        off_z = q_b[30:0];
            end
            cfgt_pkg::FACE_PZ:
            begin
                off_x = q_a[30:0];  off_y = q_b[30:0]; off_z = ext_z_reg;
            end
            default:
            begin
                off_x = q_a[30:0];  off_y = q_b[30:0]; off_z = '0;
            end
        endcase
        px_next = sat_add(org_x_reg, off_x);
        py_next = sat_add(org_y_reg, off_y);
        pz_next = sat_add(org_z_reg, off_z);
        tu_next = q_u[16:0];
        tv_next = q_v[16:0];
        // mirrored texel axes
        if ((ct.face == cfgt_pkg::FACE_PX) || (ct.face == cfgt_pkg::FACE_NZ))
            tu_next = 17'd65536 - tu_next;
        if (ct.face == cfgt_pkg::FACE_PY)
            tv_next = 17'd65536 - tv_next;

        ib = ct.a + IW'(1);
        id = ct.a + ct.w;
        ic = id + IW'(1);
        if ((ct.face == cfgt_pkg::FACE_NX) || (ct.face == cfgt_pkg::FACE_NY)
            || (ct.face == cfgt_pkg::FACE_PZ))
        begin
            ia_next = ct.a;
            ib_next = ct.tri2 ? ic : ib;
            ic_next = ct.tri2 ? id : ic;
        end
        else
        begin
            ia_next = ct.tri2 ? ct.a : ib;
            ib_next = ct.tri2 ? id : ct.a;
            ic_next = ic;
        end
    end

    logic        strobe_reg, last_reg;
    logic [31:0] px_reg, py_reg, pz_reg;
    logic [16:0] tu_reg, tv_reg;
    logic [2:0]  nd_reg, td_reg, bd_reg;
    logic [14:0] ia_reg, ib_reg, ic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= ct.valid;
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= ct.op ? '0 : px_next;
        py_reg   <= ct.op ? '0 : py_next;
        pz_reg   <= ct.op ? '0 : pz_next;
        tu_reg   <= ct.op ? '0 : tu_next;
        tv_reg   <= ct.op ? '0 : tv_next;
        nd_reg   <= ct.op ? '0 : ct.face;
        td_reg   <= ct.op ? '0 : cfgt_pkg::dir_tangent(ct.face);
        bd_reg   <= ct.op ? '0 : cfgt_pkg::dir_bitangent(ct.face);
        ia_reg   <= ct.op ? 15'(ia_next) : '0;
        ib_reg   <= ct.op ? 15'(ib_next) : '0;
        ic_reg   <= ct.op ? 15'(ic_next) : '0;
        last_reg <= !ct.op || ct.tri2;
    end

    assign strobe        = strobe_reg;
    assign pos_x         = px_reg;
    assign pos_y         = py_reg;
    assign pos_z         = pz_reg;
    assign tex_u         = tu_reg;
    assign tex_v         = tv_reg;
    assign normal_dir    = nd_reg;
    assign tangent_dir   = td_reg;
    assign bitangent_dir = bd_reg;
    assign index_a       = ia_reg;
    assign index_b       = ib_reg;
    assign index_c       = ic_reg;
    assign last          = last_reg;

    `CHK_NEXT(a_quad_blocks, clk, rst_n, start && !busy && op, busy, "quad request did not raise busy")
    `CHK_NEXT(a_busy_once, clk, rst_n, busy, !busy, "busy held for more than one cycle")
    `CHK_NEXT(a_tri_pair, clk, rst_n, strobe && !last, strobe && last, "first triangle not followed by second")
    `CHK_NOW(a_vert_idx, clk, rst_n, strobe && last && (index_a == '0) && (index_b == '0) && (index_c == '0) && (tex_u != '0), normal_dir <= cfgt_pkg::FACE_NZ, "vertex result with bad normal")

endmodule
